[rtl/dbsl_pkg.sv]
// Shared types, constants and register codes for the deadband sample logger.
package dbsl_pkg;

    localparam int NUM_DEVICES = 8;
    localparam int MASK_W      = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PH_THR         = 3'd0,
        REG_ORP_THR        = 3'd1,
        REG_PRESSURE_THR   = 3'd2,
        REG_WATER_TEMP_THR = 3'd3,
        REG_AIR_TEMP_THR   = 3'd4,
        REG_MIN_INTERVAL   = 3'd5,
        REG_MAX_INTERVAL   = 3'd6,
        REG_TIME_FLOOR     = 3'd7
    } t_cfg_idx;

    localparam logic [15:0] RST_PH_THR         = 16'd3;
    localparam logic [15:0] RST_ORP_THR        = 16'd8;
    localparam logic [15:0] RST_PRESSURE_THR   = 16'd5;
    localparam logic [15:0] RST_WATER_TEMP_THR = 16'd2;
    localparam logic [15:0] RST_AIR_TEMP_THR   = 16'd5;
    localparam logic [31:0] RST_MIN_INTERVAL   = 32'd60;
    localparam logic [31:0] RST_MAX_INTERVAL   = 32'd600;
    localparam logic [31:0] RST_TIME_FLOOR     = 32'd1704067200;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_CLEAR  = 1'b1;
    localparam logic KIND_EVENT  = 1'b0;
    localparam logic KIND_RECORD = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [31:0]       now_ts;
        logic signed [15:0] ph_in;
        logic signed [15:0] orp_in;
        logic signed [15:0] pressure_in;
        logic signed [15:0] water_temp_in;
        logic signed [15:0] air_temp_in;
        logic [7:0]        device_mask_in;
        logic [6:0]        mode_mask_in;
    } t_in;

    typedef struct packed {
        logic              item_kind;
        logic [31:0]       out_ts;
        logic [2:0]        device_index;
        logic              device_on;
        logic signed [15:0] rec_ph;
        logic signed [15:0] rec_orp;
        logic signed [15:0] rec_pressure;
        logic signed [15:0] rec_water_temp;
        logic signed [15:0] rec_air_temp;
        logic [7:0]        rec_devices;
        logic [6:0]        rec_modes;
        logic              last_of_run;
    } t_out;

    // One classified sample waiting for the back end.
    typedef struct packed {
        logic [31:0]        ts;
        logic [MASK_W-1:0]  evt_mask;
        logic               sig;
        logic [7:0]         devices;
        logic [6:0]         modes;
        logic signed [15:0] ph;
        logic signed [15:0] orp;
        logic signed [15:0] pressure;
        logic signed [15:0] water_temp;
        logic signed [15:0] air_temp;
    } t_job;

    // Bits of the device mask that may raise change events.
    function automatic logic [MASK_W-1:0] event_enable();
        logic [MASK_W-1:0] m;
        for (int i = 0; i < MASK_W; i++) begin
            m[i] = (i < NUM_DEVICES);
        end
        return m;
    endfunction

endpackage

[rtl/dbsl_front.sv]
// Front end: configuration registers, logger state and sample classification.
module dbsl_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [dbsl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dbsl_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic               i_accept,
    input  dbsl_pkg::t_in      i_data,
    output logic               o_push,
    output dbsl_pkg::t_job     o_job
);
    import dbsl_pkg::*;

    logic [15:0] r_ph_thr, r_orp_thr, r_pressure_thr, r_water_temp_thr, r_air_temp_thr;
    logic [31:0] r_min_interval, r_max_interval, r_time_floor;

    logic signed [15:0] r_last_ph, r_last_orp, r_last_pressure;
    logic signed [15:0] r_last_water_temp, r_last_air_temp;
    logic [7:0]  r_last_record_devices;
    logic [31:0] r_last_record_ts;
    logic        r_record_seen;
    logic [7:0]  r_prev_devices;
    logic        r_prev_devices_valid;

    logic        sample_ok;
    logic [31:0] elapsed;
    logic        any_moved;
    logic        sig;
    logic [MASK_W-1:0] evt_mask;

    function automatic logic moved(logic signed [15:0] now_v, logic signed [15:0] last_v,
                                   logic [15:0] thr);
        logic signed [16:0] d;
        logic [16:0]        mag;
        d   = 17'(now_v) - 17'(last_v);
        mag = d[16] ? 17'(-d) : 17'(d);
        return mag >= {1'b0, thr};
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph_thr         <= RST_PH_THR;
            r_orp_thr        <= RST_ORP_THR;
            r_pressure_thr   <= RST_PRESSURE_THR;
            r_water_temp_thr <= RST_WATER_TEMP_THR;
            r_air_temp_thr   <= RST_AIR_TEMP_THR;
            r_min_interval   <= RST_MIN_INTERVAL;
            r_max_interval   <= RST_MAX_INTERVAL;
            r_time_floor     <= RST_TIME_FLOOR;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                REG_PH_THR:         r_ph_thr         <= i_cfg_wdata[15:0];
                REG_ORP_THR:        r_orp_thr        <= i_cfg_wdata[15:0];
                REG_PRESSURE_THR:   r_pressure_thr   <= i_cfg_wdata[15:0];
                REG_WATER_TEMP_THR: r_water_temp_thr <= i_cfg_wdata[15:0];
                REG_AIR_TEMP_THR:   r_air_temp_thr   <= i_cfg_wdata[15:0];
                REG_MIN_INTERVAL:   r_min_interval   <= i_cfg_wdata;
                REG_MAX_INTERVAL:   r_max_interval   <= i_cfg_wdata;
                REG_TIME_FLOOR:     r_time_floor     <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        sample_ok = i_accept && (i_data.req_type == REQ_SAMPLE)
                    && (i_data.now_ts >= r_time_floor);
        elapsed   = i_data.now_ts - r_last_record_ts;
        any_moved = moved(i_data.ph_in, r_last_ph, r_ph_thr)
                 || moved(i_data.orp_in, r_last_orp, r_orp_thr)
                 || moved(i_data.pressure_in, r_last_pressure, r_pressure_thr)
                 || moved(i_data.water_temp_in, r_last_water_temp, r_water_temp_thr)
                 || moved(i_data.air_temp_in, r_last_air_temp, r_air_temp_thr)
                 || (i_data.device_mask_in != r_last_record_devices);
        sig = !r_record_seen || (elapsed >= r_max_interval)
              || ((elapsed >= r_min_interval) && any_moved);
        evt_mask = r_prev_devices_valid
                   ? ((i_data.device_mask_in ^ r_prev_devices) & event_enable())
                   : '0;

        o_push           = sample_ok && (sig || (evt_mask != '0));
        o_job.ts         = i_data.now_ts;
        o_job.evt_mask   = evt_mask;
        o_job.sig        = sig;
        o_job.devices    = i_data.device_mask_in;
        o_job.modes      = i_data.mode_mask_in;
        o_job.ph         = i_data.ph_in;
        o_job.orp        = i_data.orp_in;
        o_job.pressure   = i_data.pressure_in;
        o_job.water_temp = i_data.water_temp_in;
        o_job.air_temp   = i_data.air_temp_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_data.req_type == REQ_CLEAR)) begin
            r_last_ph             <= '0;
            r_last_orp            <= '0;
            r_last_pressure       <= '0;
            r_last_water_temp     <= '0;
            r_last_air_temp       <= '0;
            r_last_record_devices <= '0;
            r_last_record_ts      <= '0;
            r_record_seen         <= 1'b0;
            r_prev_devices        <= '0;
            r_prev_devices_valid  <= 1'b0;
        end else if (sample_ok) begin
            r_prev_devices       <= i_data.device_mask_in;
            r_prev_devices_valid <= 1'b1;
            if (sig) begin
                r_last_ph             <= i_data.ph_in;
                r_last_orp            <= i_data.orp_in;
                r_last_pressure       <= i_data.pressure_in;
                r_last_water_temp     <= i_data.water_temp_in;
                r_last_air_temp       <= i_data.air_temp_in;
                r_last_record_devices <= i_data.device_mask_in;
                r_last_record_ts      <= i_data.now_ts;
                r_record_seen         <= 1'b1;
            end
        end
    end

endmodule

[rtl/dbsl_queue.sv]
// Short job queue between the classifying front end and the emitting back end.
module dbsl_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dbsl_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output dbsl_pkg::t_job o_head
);
    import dbsl_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            r_count <= r_count + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

endmodule

[rtl/dbsl_back.sv]
// Back end: expands each job into change events and, if significant, a record, one per cycle unless stalled.
module dbsl_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    input  dbsl_pkg::t_job i_q_head,
    output logic           o_q_pop,
    output logic           o_valid,
    input  logic           i_stall,
    output dbsl_pkg::t_out o_data
);
    import dbsl_pkg::*;

    t_job  r_w;
    logic  r_w_valid;
    logic  r_out_valid;
    t_out  r_out;

    logic              adv, emit, is_evt, last;
    logic [2:0]        low_idx;
    logic [MASK_W-1:0] cleared;
    t_out              n_out;

    always_comb begin
        low_idx = '0;
        for (int i = MASK_W - 1; i >= 0; i--) begin
            if (r_w.evt_mask[i]) low_idx = 3'(i);
        end
        cleared = r_w.evt_mask & (r_w.evt_mask - 1'b1);
        is_evt  = (r_w.evt_mask != '0);
        last    = is_evt ? ((cleared == '0) && !r_w.sig) : 1'b1;
        adv     = !r_out_valid || !i_stall;
        emit    = adv && r_w_valid;
        o_q_pop = !i_q_empty && (!r_w_valid || (emit && last));

        n_out             = '0;
        n_out.out_ts      = r_w.ts;
        n_out.last_of_run = last;
        if (is_evt) begin
            n_out.item_kind    = KIND_EVENT;
            n_out.device_index = low_idx;
            n_out.device_on    = r_w.devices[low_idx];
        end else begin
            n_out.item_kind      = KIND_RECORD;
            n_out.rec_ph         = r_w.ph;
            n_out.rec_orp        = r_w.orp;
            n_out.rec_pressure   = r_w.pressure;
            n_out.rec_water_temp = r_w.water_temp;
            n_out.rec_air_temp   = r_w.air_temp;
            n_out.rec_devices    = r_w.devices;
            n_out.rec_modes      = r_w.modes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // Refill the working slot as soon as the current job finishes.
            if (o_q_pop) begin
                r_w_valid <= 1'b1;
            end else if (emit && last) begin
                r_w_valid <= 1'b0;
            end
            if (adv) r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_w <= i_q_head;
        end else if (emit && is_evt) begin
            r_w.evt_mask <= cleared;
        end
        if (emit) r_out <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

[rtl/deadband_sample_logger.sv]
// Top level of the deadband sample logger: front end, job queue and back end.
//
//  channel   direction  handshake                 payload
//  input     in         i_in_valid / o_in_stall   i_in_data   (t_in)
//  output    out        o_out_valid / i_out_stall o_out_data  (t_out)
//  config    in         i_cfg_we                  i_cfg_idx, i_cfg_wdata
//
// A sample is classified in the cycle it is accepted; its results (1 to 9 of
// them) leave one per cycle from the back end while the output is not stalled.
// The output register is the limit on sustained rate.
// A four-entry job queue lets new samples enter while results are still going
// out; o_in_stall rises only when that queue is full. Reset is synchronous and
// returns all registers to their reset values and the logger state to empty.
module deadband_sample_logger (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  dbsl_pkg::t_in                   i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output dbsl_pkg::t_out                  o_out_data,
    input  logic                            i_cfg_we,
    input  logic [dbsl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dbsl_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import dbsl_pkg::*;

    logic accept, push, full, pop, empty;
    t_job job, head;

    assign o_in_stall = full;
    assign accept     = i_in_valid && !full;

    dbsl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_data      (i_in_data),
        .o_push      (push),
        .o_job       (job)
    );

    dbsl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_head  (head)
    );

    dbsl_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (empty),
        .i_q_head  (head),
        .o_q_pop   (pop),
        .o_valid   (o_out_valid),
        .i_stall   (i_out_stall),
        .o_data    (o_out_data)
    );

endmodule

[test/deadband_sample_logger_checker.sv]
`timescale 1ns / 100ps
// Checker for the deadband sample logger: predicts every result and compares the output stream.
module deadband_sample_logger_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  dbsl_pkg::t_in                   i_in_data,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  dbsl_pkg::t_out                  i_out_data,
    input  logic                            i_cfg_we,
    input  logic [dbsl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dbsl_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output int                              o_fail_count,
    output int                              o_pending
);
    import dbsl_pkg::*;

    // Thresholds in field order: pH, ORP, pressure, water temperature, air temperature.
    logic [15:0]        thr [5];
    logic [31:0]        min_iv;
    logic [31:0]        max_iv;
    logic [31:0]        ts_floor;

    logic signed [15:0] rec_val [5];
    logic [7:0]         rec_devices;
    logic [31:0]        rec_ts;
    logic               rec_seen;
    logic [7:0]         seen_devices;
    logic               seen_valid;

    t_out               due_items [$];

    task automatic restore_registers();
        thr[0]   = RST_PH_THR;
        thr[1]   = RST_ORP_THR;
        thr[2]   = RST_PRESSURE_THR;
        thr[3]   = RST_WATER_TEMP_THR;
        thr[4]   = RST_AIR_TEMP_THR;
        min_iv   = RST_MIN_INTERVAL;
        max_iv   = RST_MAX_INTERVAL;
        ts_floor = RST_TIME_FLOOR;
    endtask

    task automatic clear_logger();
        int k;
        for (k = 0; k < 5; k++) rec_val[k] = '0;
        rec_devices  = '0;
        rec_ts       = '0;
        rec_seen     = 1'b0;
        seen_devices = '0;
        seen_valid   = 1'b0;
    endtask

    function automatic bit moved_by(logic signed [15:0] now_v, logic signed [15:0] was_v,
                                    logic [15:0] limit);
        int diff;
        diff = int'(now_v) - int'(was_v);
        if (diff < 0) diff = -diff;
        return diff >= int'({16'd0, limit});
    endfunction

    // Work out the events and the record that one accepted sample causes.
    task automatic log_sample(input t_in x);
        logic signed [15:0] v [5];
        logic [31:0]        elapsed;
        logic [7:0]         flips;
        bit                 sig;
        bit                 any_move;
        int                 n_events;
        int                 k;
        int                 i;
        t_out               r;

        v[0] = x.ph_in;
        v[1] = x.orp_in;
        v[2] = x.pressure_in;
        v[3] = x.water_temp_in;
        v[4] = x.air_temp_in;

        if (x.req_type == REQ_CLEAR) begin
            clear_logger();
        end else if (x.now_ts >= ts_floor) begin
            elapsed  = x.now_ts - rec_ts;
            any_move = 1'b0;
            for (i = 0; i < 5; i++) begin
                if (moved_by(v[i], rec_val[i], thr[i])) any_move = 1'b1;
            end
            sig = (elapsed >= max_iv) ||
                  (elapsed >= min_iv && (any_move || x.device_mask_in != rec_devices));
            if (!rec_seen) sig = 1'b1;

            flips    = seen_valid ? (x.device_mask_in ^ seen_devices) : 8'h00;
            n_events = 0;
            for (i = 0; i < NUM_DEVICES && i < 8; i++) begin
                if (flips[i]) n_events++;
            end
            k = 0;
            for (i = 0; i < NUM_DEVICES && i < 8; i++) begin
                if (flips[i]) begin
                    k++;
                    r              = '0;
                    r.item_kind    = KIND_EVENT;
                    r.out_ts       = x.now_ts;
                    r.device_index = 3'(i);
                    r.device_on    = x.device_mask_in[i];
                    r.last_of_run  = !sig && (k == n_events);
                    due_items.push_back(r);
                end
            end
            seen_devices = x.device_mask_in;
            seen_valid   = 1'b1;

            if (sig) begin
                r                = '0;
                r.item_kind      = KIND_RECORD;
                r.out_ts         = x.now_ts;
                r.rec_ph         = v[0];
                r.rec_orp        = v[1];
                r.rec_pressure   = v[2];
                r.rec_water_temp = v[3];
                r.rec_air_temp   = v[4];
                r.rec_devices    = x.device_mask_in;
                r.rec_modes      = x.mode_mask_in;
                r.last_of_run    = 1'b1;
                due_items.push_back(r);
                for (i = 0; i < 5; i++) rec_val[i] = v[i];
                rec_devices = x.device_mask_in;
                rec_ts      = x.now_ts;
                rec_seen    = 1'b1;
            end
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            o_fail_count++;
        end
    endtask

    task automatic compare_item(input t_out got);
        t_out want;
        if (due_items.size() == 0) begin
            $display("%0t: unexpected transaction, expected none, got %h", $time, got);
            o_fail_count++;
        end else begin
            want = due_items.pop_front();
            check_field("item_kind",      32'(want.item_kind),      32'(got.item_kind));
            check_field("out_ts",         want.out_ts,              got.out_ts);
            check_field("device_index",   32'(want.device_index),   32'(got.device_index));
            check_field("device_on",      32'(want.device_on),      32'(got.device_on));
            check_field("rec_ph",         32'(want.rec_ph),         32'(got.rec_ph));
            check_field("rec_orp",        32'(want.rec_orp),        32'(got.rec_orp));
            check_field("rec_pressure",   32'(want.rec_pressure),   32'(got.rec_pressure));
            check_field("rec_water_temp", 32'(want.rec_water_temp), 32'(got.rec_water_temp));
            check_field("rec_air_temp",   32'(want.rec_air_temp),   32'(got.rec_air_temp));
            check_field("rec_devices",    32'(want.rec_devices),    32'(got.rec_devices));
            check_field("rec_modes",      32'(want.rec_modes),      32'(got.rec_modes));
            check_field("last_of_run",    32'(want.last_of_run),    32'(got.last_of_run));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restore_registers();
            clear_logger();
            due_items.delete();
            o_fail_count = 0;
        end else begin
            if (i_out_valid && !i_out_stall) compare_item(i_out_data);
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    REG_PH_THR:         thr[0]   = i_cfg_wdata[15:0];
                    REG_ORP_THR:        thr[1]   = i_cfg_wdata[15:0];
                    REG_PRESSURE_THR:   thr[2]   = i_cfg_wdata[15:0];
                    REG_WATER_TEMP_THR: thr[3]   = i_cfg_wdata[15:0];
                    REG_AIR_TEMP_THR:   thr[4]   = i_cfg_wdata[15:0];
                    REG_MIN_INTERVAL:   min_iv   = i_cfg_wdata;
                    REG_MAX_INTERVAL:   max_iv   = i_cfg_wdata;
                    REG_TIME_FLOOR:     ts_floor = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) log_sample(i_in_data);
        end
        o_pending = due_items.size();
    end

endmodule

[test/deadband_sample_logger_test.sv]
`timescale 1ns / 100ps
// Top of the deadband sample logger testbench: clock, reset, stimulus and verdict.
module deadband_sample_logger_test;
    import dbsl_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 300;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    t_in                   in_data   = '0;
    logic                  out_stall = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    logic                  in_stall;
    logic                  out_valid;
    t_out                  out_data;
    int                    fail_count;
    int                    pending;

    bit                    calm        = 1'b0;
    int                    hold_ticket = 0;
    int                    hold_seen   = 0;
    int                    hold_left   = 0;
    int                    cycle_count = 0;

    // Shape of the well-formed sample stream.
    logic [31:0]           cur_ts;
    logic [31:0]           floor_now;
    logic [31:0]           min_now;
    logic signed [15:0]    cur_v [5];
    logic [7:0]            cur_dev;

    deadband_sample_logger dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    deadband_sample_logger_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #2 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("deadband_sample_logger_test NOT OK");
            $finish;
        end
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(negedge clk) begin
        if (hold_ticket != hold_seen) begin
            hold_seen <= hold_ticket;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= !calm && ($urandom_range(99) < 13);
        end
    end

    function automatic t_in sample_of(logic req, logic [31:0] ts,
                                      logic signed [15:0] ph, logic signed [15:0] orp,
                                      logic signed [15:0] pr, logic signed [15:0] wt,
                                      logic signed [15:0] at, logic [7:0] dev,
                                      logic [6:0] modes);
        t_in s;
        s.req_type       = req;
        s.now_ts         = ts;
        s.ph_in          = ph;
        s.orp_in         = orp;
        s.pressure_in    = pr;
        s.water_temp_in  = wt;
        s.air_temp_in    = at;
        s.device_mask_in = dev;
        s.mode_mask_in   = modes;
        return s;
    endfunction

    // Mostly well-formed samples with drifting values; some clears and raw noise.
    function automatic t_in next_sample();
        t_in s;
        int  pick;
        int  f;
        pick = $urandom_range(99);
        if (pick < 4) begin
            s          = {$urandom, $urandom, $urandom, $urandom};
            s.req_type = REQ_CLEAR;
        end else if (pick < 14) begin
            s          = {$urandom, $urandom, $urandom, $urandom};
            s.req_type = REQ_SAMPLE;
        end else begin
            case ($urandom_range(9))
                0, 1, 2, 3: cur_ts = cur_ts + $urandom_range(20);
                4, 5, 6:    cur_ts = cur_ts + min_now - 3 + $urandom_range(8);
                7:          cur_ts = cur_ts + $urandom_range(620, 280);
                8:          cur_ts = cur_ts - $urandom_range(400, 1);
                default:    cur_ts = cur_ts + $urandom;
            endcase
            if (cur_ts < floor_now) cur_ts = floor_now + $urandom_range(50);
            for (f = 0; f < 5; f++) begin
                pick = $urandom_range(19);
                if (pick == 19) cur_v[f] = 16'($urandom);
                else if (pick >= 8) cur_v[f] = cur_v[f] + 16'($urandom_range(20)) - 16'sd10;
            end
            pick = $urandom_range(9);
            if (pick == 9) cur_dev = 8'($urandom);
            else if (pick >= 5) cur_dev[$urandom_range(7)] = ~cur_dev[$urandom_range(7)];
            s = sample_of(REQ_SAMPLE, cur_ts, cur_v[0], cur_v[1], cur_v[2], cur_v[3],
                          cur_v[4], cur_dev, 7'($urandom));
        end
        return s;
    endfunction

    task automatic offer_sample(input t_in item);
        while (!calm && $urandom_range(99) < 13) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic random_run(input int count);
        int n;
        for (n = 0; n < count; n++) offer_sample(next_sample());
    endtask

    // Hold the sender until every expected result is out, then let the pipeline empty.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (16) @(negedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_config(input logic [15:0] ph, input logic [15:0] orp,
                              input logic [15:0] pr, input logic [15:0] wt,
                              input logic [15:0] at, input logic [31:0] min_s,
                              input logic [31:0] max_s, input logic [31:0] floor_s);
        write_reg(REG_PH_THR,         {16'd0, ph});
        write_reg(REG_ORP_THR,        {16'd0, orp});
        write_reg(REG_PRESSURE_THR,   {16'd0, pr});
        write_reg(REG_WATER_TEMP_THR, {16'd0, wt});
        write_reg(REG_AIR_TEMP_THR,   {16'd0, at});
        write_reg(REG_MIN_INTERVAL,   min_s);
        write_reg(REG_MAX_INTERVAL,   max_s);
        write_reg(REG_TIME_FLOOR,     floor_s);
        min_now   = min_s;
        floor_now = floor_s;
    endtask

    initial begin
        t_in         s;
        logic [31:0] fl;
        int          f;

        fl        = RST_TIME_FLOOR;
        floor_now = RST_TIME_FLOOR;
        min_now   = RST_MIN_INTERVAL;
        cur_ts    = fl;
        cur_dev   = '0;
        for (f = 0; f < 5; f++) cur_v[f] = '0;

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed sequence at reset register values.
        offer_sample(sample_of(REQ_SAMPLE, fl - 1, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                               16'sh7FFF, 16'sh7FFF, 8'hFF, 7'h7F));
        s = sample_of(REQ_SAMPLE, fl, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
                      16'sh8000, 8'hA5, 7'h7F);
        offer_sample(s);
        s.now_ts = fl + 1;   s.device_mask_in = 8'h5A;  offer_sample(s);
        s.now_ts = fl + 61;  offer_sample(s);
        s.now_ts = fl + 122; s.ph_in = 16'sh8002;       offer_sample(s);
        s.now_ts = fl + 183; s.ph_in = 16'sh8003;       offer_sample(s);
        s.now_ts = fl + 184; s.ph_in = 16'sh7FFF;       offer_sample(s);
        s.now_ts = fl + 783; offer_sample(s);
        s.now_ts = fl + 800; s.device_mask_in = 8'hFF;  offer_sample(s);
        s.now_ts = fl + 900; offer_sample(s);
        // timestamp stepping back reads as a very long interval
        s.now_ts = fl + 500; offer_sample(s);
        s.now_ts = 32'hFFFF_FFFF; s.device_mask_in = 8'h00; s.orp_in = 16'sh8001;
        offer_sample(s);
        s          = {$urandom, $urandom, $urandom, $urandom};
        s.req_type = REQ_CLEAR;
        offer_sample(s);
        s = sample_of(REQ_SAMPLE, fl + 5, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                      8'h0F, 7'h55);
        offer_sample(s);
        s.now_ts = fl + 65;  s.orp_in = 16'sd7;          offer_sample(s);
        s.now_ts = fl + 66;  s.orp_in = 16'sd8;          offer_sample(s);
        s.now_ts = fl + 126; s.pressure_in = -16'sd4;    offer_sample(s);
        s.now_ts = fl + 127; s.pressure_in = -16'sd5;    offer_sample(s);
        s.now_ts = fl + 187; s.water_temp_in = 16'sd1;   offer_sample(s);
        s.now_ts = fl + 188; s.water_temp_in = 16'sd2;   offer_sample(s);
        s.now_ts = fl + 248; s.air_temp_in = -16'sd4;    offer_sample(s);
        s.now_ts = fl + 249; s.air_temp_in = -16'sd5;    offer_sample(s);
        s.now_ts = fl + 309; s.mode_mask_in = 7'h00;     offer_sample(s);
        wait_drained();

        // Zero thresholds and no floor: every valid sample makes a record.
        set_config(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                   32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
        cur_ts = $urandom;
        random_run(60);
        wait_drained();

        // Widest thresholds and intervals: almost only change events.
        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
        random_run(30);
        wait_drained();

        // Highest floor: only the last second of the range gets through.
        write_reg(REG_TIME_FLOOR, 32'hFFFF_FFFF);
        floor_now = 32'hFFFF_FFFF;
        s = sample_of(REQ_SAMPLE, 32'hFFFF_FFFE, 16'sd1, 16'sd2, 16'sd3, 16'sd4, 16'sd5,
                      8'h3C, 7'h01);
        offer_sample(s);
        s.now_ts = 32'hFFFF_FFFF; offer_sample(s);
        s.device_mask_in = 8'hC3; offer_sample(s);
        random_run(4);
        wait_drained();

        // Mid settings: the bulk of the random traffic.
        set_config(16'($urandom_range(20, 1)), 16'($urandom_range(20, 1)),
                   16'($urandom_range(20, 1)), 16'($urandom_range(20, 1)),
                   16'($urandom_range(20, 1)), 32'd30, 32'd300, 32'd1000000);
        cur_ts = 32'd1001000;
        random_run(70);
        calm = 1'b1;
        random_run(60);
        calm = 1'b0;
        // long receiver hold-off while samples keep coming, so the queue fills
        hold_ticket = hold_ticket + 1;
        random_run(20);
        wait_drained();
        random_run(50);
        wait_drained();

        set_config(RST_PH_THR, RST_ORP_THR, RST_PRESSURE_THR, RST_WATER_TEMP_THR,
                   RST_AIR_TEMP_THR, RST_MIN_INTERVAL, RST_MAX_INTERVAL, RST_TIME_FLOOR);
        cur_ts = RST_TIME_FLOOR + 32'd100;
        random_run(100);
        wait_drained();
        repeat (30) @(negedge clk);

        if (fail_count == 0) begin
            $display("deadband_sample_logger_test OK");
        end else begin
            $display("deadband_sample_logger_test NOT OK");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/dbsl_pkg.sv
rtl/dbsl_front.sv
rtl/dbsl_queue.sv
rtl/dbsl_back.sv
rtl/deadband_sample_logger.sv
test/deadband_sample_logger_checker.sv
test/deadband_sample_logger_test.sv
